FILE: sv/shfm_pkg.sv
// ----------------------------------------------------------------------------
// shfm_pkg
// Shared types and constants for the string hash block (FNV-1a / multiply-fold).
// ----------------------------------------------------------------------------
package shfm_pkg;

    localparam logic [63:0] MIX_P0    = 64'ha0761d6478bd642f;
    localparam logic [63:0] MIX_P1    = 64'he7037ed1a0b428db;
    localparam logic [63:0] SEED_BASE = 64'h9e3779b97f4a7c15;
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;

    localparam logic [15:0] THRESH_RESET = 16'd16;

    localparam int DIGIT_W = 8;
    localparam int STEPS   = 64 / DIGIT_W;
    localparam int STEP_W  = $clog2(STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_FIN1,
        ST_FIN2,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    // x * 16777619 mod 2^32, prime = 2^24 + 403
    function automatic logic [31:0] fnv_mul(input logic [31:0] x);
        logic [40:0] small_prod;
        small_prod = {9'd0, x} * 41'd403;
        return {x[7:0], 24'd0} + small_prod[31:0];
    endfunction

endpackage

FILE: sv/shfm_fold_mul.sv
// ----------------------------------------------------------------------------
// shfm_fold_mul
// Digit-serial 64x64->128 multiplier, one 8-bit digit of b per cycle; the
// result is the XOR of the product's low and high halves.
// ----------------------------------------------------------------------------
module shfm_fold_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  shfm_pkg::mul_req_t    req,
    output logic                  done,
    output logic [63:0]           result
);
    import shfm_pkg::*;

    logic [63:0]       a_reg;
    logic [63:0]       b_reg;
    logic [127:0]      prod_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [71:0]       partial;

    assign partial = {8'd0, prod_reg[127:64]} + ({8'd0, a_reg} * {64'd0, b_reg[DIGIT_W-1:0]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg    <= req.a;
            b_reg    <= req.b;
            prod_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg    <= {{DIGIT_W{1'b0}}, b_reg[63:DIGIT_W]};
            prod_reg <= {partial, prod_reg[63:DIGIT_W]};
        end
    end

    assign done   = done_reg;
    assign result = prod_reg[63:0] ^ prod_reg[127:64];

endmodule

FILE: sv/string_hash_fnv_or_multiply_fold_top.sv
// ----------------------------------------------------------------------------
// string_hash_fnv_or_multiply_fold_top
// Byte-stream string hash: FNV-1a for short strings, 64-bit multiply-fold
// for strings at or above the bulk threshold.
// ----------------------------------------------------------------------------
// Input stream: one byte per transaction. tuser[0] starts a string (the
// declared length in tdata is read then), tuser[1] flags an empty string,
// tlast marks the final byte. Output stream: one 32-bit hash per string.
// FNV-1a bytes are folded in as they are accepted; the hash of an FNV string, or of an empty
// string under a nonzero threshold, is presented the cycle after the last
// transaction. With a zero threshold an empty string runs the bulk finish.
// Multiply-fold bytes are staged into a 64-bit word; on every eighth byte the serial
// 64x64 multiplier (8 bits per cycle) folds the word into the seed. The finish
// runs two more folds before the hash shows.
// One string item is worked at a time; s_tready is low while a fold runs.
// A finished hash sits in the output register; new bytes that produce no hash
// are still taken while it waits. If the receiver stalls, a second hash waits
// inside and the input is held off. Reset clears the hash state to the FNV
// offset basis and the threshold to 16. cfg_we writes the threshold.
module string_hash_fnv_or_multiply_fold_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,     // bulk_threshold
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // [7:0] data_byte, [38:8] declared_len
    input  logic [1:0]  s_tuser,       // [0] first_byte, [1] empty_string
    input  logic        s_tlast,       // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // hash_value
);
    import shfm_pkg::*;

    state_t      state_reg, state_next;
    logic [15:0] thresh_reg;
    logic        bulk_mode_reg, bulk_mode_next;
    logic [31:0] fnv_reg, fnv_next;
    logic [63:0] seed_reg, seed_next;
    logic [63:0] stage_word_reg, stage_word_next;
    logic [2:0]  stage_count_reg, stage_count_next;
    logic        last_pend_reg, last_pend_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    mul_req_t    mreq;
    logic        mul_done;
    logic [63:0] mul_result;

    logic [7:0]  in_byte;
    logic [30:0] in_len;
    logic        in_first, in_empty, accept, out_free;
    logic        mode_b;
    logic [31:0] fnv_b;
    logic [63:0] seed_b, word_b;
    logic [2:0]  cnt_b;

    assign in_byte  = s_tdata[7:0];
    assign in_len   = s_tdata[38:8];
    assign in_first = s_tuser[0];
    assign in_empty = s_tuser[1];
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && (out_free || !(s_tlast || in_empty));
    assign accept   = s_tvalid && s_tready;

    shfm_fold_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mreq),
        .done   (mul_done),
        .result (mul_result)
    );

    always_comb
    begin
        mode_b = in_first ? ({1'b0, in_len} >= {16'd0, thresh_reg}) : bulk_mode_reg;
        fnv_b  = in_first ? FNV_BASIS : fnv_reg;
        seed_b = in_first ? (SEED_BASE ^ {33'd0, in_len}) : seed_reg;
        cnt_b  = in_first ? 3'd0 : stage_count_reg;
        word_b = in_first ? 64'd0 : stage_word_reg;
        word_b[{cnt_b, 3'b000} +: 8] = in_byte;
    end

    always_comb
    begin
        state_next       = state_reg;
        bulk_mode_next   = bulk_mode_reg;
        fnv_next         = fnv_reg;
        seed_next        = seed_reg;
        stage_word_next  = stage_word_reg;
        stage_count_next = stage_count_reg;
        last_pend_next   = last_pend_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        mreq             = '{start: 1'b0, a: 64'd0, b: 64'd0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_empty)
                    begin
                        if (thresh_reg != 16'd0)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = FNV_BASIS;
                        end
                        else
                        begin
                            mreq       = '{start: 1'b1, a: MIX_P0, b: SEED_BASE ^ MIX_P1};
                            state_next = ST_FIN1;
                        end
                    end
                    else
                    begin
                        bulk_mode_next = mode_b;
                        fnv_next       = fnv_b;
                        seed_next      = seed_b;
                        if (!mode_b)
                        begin
                            fnv_next         = fnv_mul(fnv_b ^ {24'd0, in_byte});
                            stage_word_next  = word_b;
                            stage_count_next = cnt_b;
                            if (s_tlast)
                            begin
                                out_valid_next = 1'b1;
                                out_data_next  = fnv_mul(fnv_b ^ {24'd0, in_byte});
                            end
                        end
                        else if (cnt_b == 3'd7)
                        begin
                            stage_word_next  = 64'd0;
                            stage_count_next = 3'd0;
                            last_pend_next   = s_tlast;
                            mreq       = '{start: 1'b1, a: word_b ^ MIX_P0, b: seed_b ^ MIX_P1};
                            state_next = ST_FOLD;
                        end
                        else
                        begin
                            stage_word_next  = word_b;
                            stage_count_next = cnt_b + 3'd1;
                            if (s_tlast)
                            begin
                                mreq = '{start: 1'b1,
                                         a: word_b ^ MIX_P0 ^ {61'd0, cnt_b + 3'd1},
                                         b: seed_b ^ MIX_P1};
                                state_next = ST_FIN1;
                            end
                        end
                    end
                end
            end
            ST_FOLD:
            begin
                if (mul_done)
                begin
                    seed_next = mul_result;
                    if (last_pend_reg)
                    begin
                        mreq       = '{start: 1'b1, a: MIX_P0, b: mul_result ^ MIX_P1};
                        state_next = ST_FIN1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIN1:
            begin
                if (mul_done)
                begin
                    mreq       = '{start: 1'b1, a: mul_result, b: MIX_P1};
                    state_next = ST_FIN2;
                end
            end
            ST_FIN2, ST_EMIT:
            begin
                if (mul_done || state_reg == ST_EMIT)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = mul_result[31:0];
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            thresh_reg      <= THRESH_RESET;
            bulk_mode_reg   <= 1'b0;
            fnv_reg         <= FNV_BASIS;
            seed_reg        <= 64'd0;
            stage_word_reg  <= 64'd0;
            stage_count_reg <= 3'd0;
            last_pend_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_we)
            begin
                thresh_reg <= cfg_wdata;
            end
            bulk_mode_reg   <= bulk_mode_next;
            fnv_reg         <= fnv_next;
            seed_reg        <= seed_next;
            stage_word_reg  <= stage_word_next;
            stage_count_reg <= stage_count_next;
            last_pend_reg   <= last_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
